// ----- design/bds_pkg.sv -----
// Shared constants, types and register indexes of the 2x2 box downscaler.
`default_nettype none
package bds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);

  localparam int PIX_W   = 8;
  localparam int PSUM_W  = PIX_W + 1;
  localparam int BSUM_W  = PIX_W + 2;
  localparam int CFGW_W  = 11;
  localparam int ROW_W   = 16;
  localparam int CFG_D_W = 16;
  localparam int CFG_I_W = 1;

  localparam logic [CFG_I_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_I_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Per-word decode from the scan counters.
  typedef struct packed {
    logic              odd_col;
    logic              odd_row;
    logic              in_frame;
    logic              last_col;
    logic              last_row;
    logic [SLOT_W-1:0] slot;
  } scan_ctl_t;

endpackage
`default_nettype wire

// ----- design/box_downscale_2x2_unit.sv -----
// Top level of the 2x2 box-filter downscaler for 8-bit grey raster images.
//
//   channel | signals                                          | moves
//   --------+--------------------------------------------------+------------------------
//   in      | in_valid, in_ready, in_pixel_in                  | one source pixel word
//   out     | out_valid, out_ready, out_pixel_out/row_end/frame_end | one averaged word
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata                  | size register write
//
// One input word per clock sustained while results are accepted. A result
// from the odd-row, odd-column word that causes it passes the line store read
// (stage 1), then the output register. in_ready drops only while a result
// sits in the output register unaccepted and another result waits behind it.
// Synchronous active-low reset clears the counters, the held pixel and the valid
// flags; the line store is not cleared, as an even row writes each entry first.
`default_nettype none
module box_downscale_2x2_unit
  import bds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [CFG_I_W-1:0] cfg_index,
  input  wire logic [CFG_D_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIX_W-1:0]   in_pixel_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [PIX_W-1:0]   out_pixel_out,
  output logic                    out_row_end,
  output logic                    out_frame_end
);

  scan_ctl_t         ctl;
  logic              in_take;
  logic              make_out;   // word completes a 2x2 block
  logic              store_sum;  // word closes a pair on an even row
  logic [PSUM_W-1:0] pair_sum;
  logic [PSUM_W-1:0] upper_sum;

  logic [PIX_W-1:0]  held_r;
  // Stage 1: waiting on the line store read.
  logic              s1_valid_r;
  logic [PSUM_W-1:0] s1_pair_r;
  logic              s1_last_col_r;
  logic              s1_last_row_r;
  logic              s1_move;
  // Stage 2: output register.
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;
  logic [BSUM_W-1:0] block_sum;

  // Stage 2 frees up when empty or being drained; stage 1 moves when it can.
  assign s1_move  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_move;
  assign in_take  = in_valid && in_ready;

  assign pair_sum  = PSUM_W'(held_r) + PSUM_W'(in_pixel_in);
  assign store_sum = in_take && ctl.odd_col && !ctl.odd_row;
  assign make_out  = in_take && ctl.odd_col && ctl.odd_row && ctl.in_frame;

  bds_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_take),
    .ctl       (ctl)
  );

  // Writes on even rows and reads on odd rows never hit the same entry
  // in the same cycle, so no forwarding path is needed.
  bds_line_store u_line (
    .clk     (clk),
    .wr_en   (store_sum),
    .wr_addr (ctl.slot),
    .wr_data (pair_sum),
    .rd_en   (make_out),
    .rd_addr (ctl.slot),
    .rd_data (upper_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (in_take && !ctl.odd_col) begin
      held_r <= in_pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= make_out;
    end
  end

  always_ff @(posedge clk) begin
    if (make_out) begin
      s1_pair_r     <= pair_sum;
      s1_last_col_r <= ctl.last_col;
      s1_last_row_r <= ctl.last_row;
    end
  end

  // Round half up: (upper + lower + 2) >> 2.
  assign block_sum = BSUM_W'(upper_sum) + BSUM_W'(s1_pair_r) + BSUM_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_pix_r       <= block_sum[BSUM_W-1:2];
      out_row_end_r   <= s1_last_col_r;
      out_frame_end_r <= s1_last_col_r && s1_last_row_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule
`default_nettype wire

// ----- design/bds_line_store.sv -----
// Line store of horizontal pair sums: one write and one registered read port.
`default_nettype none
module bds_line_store
  import bds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  wire logic [PSUM_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output logic      [PSUM_W-1:0] rd_data
);

  logic [PSUM_W-1:0] mem [LINE_DEPTH];
  logic [PSUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- design/bds_scan_ctrl.sv -----
// Size registers and raster column/row counters with per-word decode.
`default_nettype none
module bds_scan_ctrl
  import bds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_I_W-1:0] cfg_index,
  input  wire logic [CFG_D_W-1:0] cfg_wdata,
  input  wire logic               step,
  output scan_ctl_t               ctl
);

  logic [WEFF_W-1:0] width_r,  width_nxt;
  logic [ROW_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r,    col_nxt;
  logic [ROW_W-1:0]  row_r,    row_nxt;
  logic [CFGW_W-1:0] w_raw;
  logic [ROW_W-1:0]  h_raw;
  logic [COL_W+1:0]  col_p1, col_p2;
  logic [ROW_W+1:0]  row_p1, row_p2;
  logic              col_wrap, row_wrap;

  assign w_raw = cfg_wdata[CFGW_W-1:0];
  assign h_raw = cfg_wdata[ROW_W-1:0];

  // Clamp sizes once at write time.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (int'(w_raw) < 2) begin
            width_nxt = WEFF_W'(2);
          end else if (int'(w_raw) > MAX_WIDTH) begin
            width_nxt = WEFF_W'(MAX_WIDTH);
          end else begin
            width_nxt = WEFF_W'(w_raw);
          end
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = (h_raw < ROW_W'(2)) ? ROW_W'(2) : h_raw;
        end
        default: begin
        end
      endcase
    end
  end

  assign col_p1   = (COL_W+2)'(col_r) + (COL_W+2)'(1);
  assign col_p2   = (COL_W+2)'(col_r) + (COL_W+2)'(2);
  assign row_p1   = (ROW_W+2)'(row_r) + (ROW_W+2)'(1);
  assign row_p2   = (ROW_W+2)'(row_r) + (ROW_W+2)'(2);
  assign col_wrap = col_p1 >= (COL_W+2)'(width_r);
  assign row_wrap = row_p1 >= (ROW_W+2)'(height_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WEFF_W'(2);
      height_r <= ROW_W'(2);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_comb begin
    ctl.odd_col  = col_r[0];
    ctl.odd_row  = row_r[0];
    ctl.in_frame = ((COL_W+1)'(col_r) < (COL_W+1)'(width_r)) && (row_r < height_r);
    ctl.last_col = col_p2 >= (COL_W+2)'(width_r);
    ctl.last_row = row_p2 >= (ROW_W+2)'(height_r);
    ctl.slot     = SLOT_W'(col_r >> 1);
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the 2x2 box-filter downscaler: scripted and random pixel streams.
`default_nettype none
module tb;
  import bds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS          = 1400;  // pixel words to send in all
  localparam int IDLE_PCT       = 29;    // chance of a bubble / stall per cycle
  localparam int SETTLE_CYCLES  = 4;     // line store read + output register, with margin
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either channel

  // One averaged output word.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } mean_word_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  // One row of the scripted opening: either a pixel word or a register write.
  // A pixel row may carry a hand-computed mean; otherwise the predictor decides.
  typedef struct packed {
    step_kind_t         kind;
    logic [CFG_I_W-1:0] reg_idx;
    logic [CFG_D_W-1:0] data;
    bit                 typed;
    mean_word_t         want;
  } script_step_t;

  localparam mean_word_t NO_MEAN = '0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_I_W-1:0] cfg_index = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               out_row_end;
  logic               out_frame_end;

  box_downscale_2x2_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the scanner, the held pixel, the pair-sum
  // line and the two size registers. Advanced once per accepted pixel word.
  // ---------------------------------------------------------------------------
  logic [CFGW_W-1:0] cfg_width  = CFGW_W'(2);
  logic [ROW_W-1:0]  cfg_height = ROW_W'(2);
  logic [PSUM_W-1:0] line_sums [LINE_DEPTH] = '{default: '0};
  logic [PIX_W-1:0]  held_pix = '0;
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  mean_word_t expected_means [$];
  int         pixels_sent = 0;
  bit         failed = 1'b0;
  int         stall_cycles = 0;

  // Stretch of the run with no bubbles and no back-pressure at all.
  wire steady = (pixels_sent >= 600) && (pixels_sent < 900);

  // Advance the scanner by one pixel; made is set when a 2x2 block completes.
  function automatic void scan_pixel(input logic [PIX_W-1:0] px, output bit made,
                                     output mean_word_t word);
    int unsigned w, h, c, r, slot, sum;
    // out-of-range sizes saturate: width to 2..MAX_WIDTH, height to at least 2
    w    = (cfg_width < 2) ? 2 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h    = (cfg_height < 2) ? 2 : cfg_height;
    c    = col_pos;
    r    = row_pos;
    slot = c >> 1;
    made = 1'b0;
    word = NO_MEAN;
    if (c % 2 == 0) begin
      held_pix = px;
    end else if (r % 2 == 0) begin
      line_sums[slot] = held_pix + px;  // 9-bit pair sum for the odd row below
    end else if (c < w && r < h) begin
      // blocks outside a shrunken image give nothing
      sum            = line_sums[slot] + held_pix + px;
      word.pixel     = PIX_W'((sum + 2) >> 2);
      word.row_end   = (c + 2 >= w);
      word.frame_end = (c + 2 >= w) && (r + 2 >= h);
      made           = 1'b1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Send one pixel word, with random bubbles before it; predict at acceptance.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input mean_word_t want);
    bit         made;
    mean_word_t word;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    scan_pixel(px, made, word);
    if (typed) expected_means.push_back(want);
    else if (made) expected_means.push_back(word);
  endtask

  // Register write, only once the block has drained and settled.
  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_width = data[CFGW_W-1:0];
    else cfg_height = data[ROW_W-1:0];
  endtask

  // Scripted opening. Mean = (sum + 2) >> 2, so halves round up.
  script_step_t script [0:28] = '{
    // all-zero block at reset size 2x2
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b1, '{8'd0, 1'b1, 1'b1}},
    // full-scale block
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd255, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd255, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd255, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd255, 1'b1, '{8'd255, 1'b1, 1'b1}},
    // sum 2: mean 0.5 rounds up to 1
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd1,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd1,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b1, '{8'd1, 1'b1, 1'b1}},
    // width 0 and height 1 both act as 2
    '{STEP_WRITE, REG_IMAGE_WIDTH,  16'd0,  1'b0, NO_MEAN},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'd1,  1'b0, NO_MEAN},
    // sum 1: mean 0.25 rounds down to 0
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd1,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0,   1'b1, '{8'd0, 1'b1, 1'b1}},
    // 3x3: odd last column and bottom row are swallowed; upper bits of width dropped
    '{STEP_WRITE, REG_IMAGE_WIDTH,  16'hF803, 1'b0, NO_MEAN},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'd3,    1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd200, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd17,  1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd99,  1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd3,   1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd250, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd128, 1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd64,  1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd32,  1'b0, NO_MEAN},
    '{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd16,  1'b0, NO_MEAN}
  };

  // ---------------------------------------------------------------------------
  // Stimulus. Width is only rewritten while the scanner sits on an even row:
  // the even row then covers every column the next odd row reads, so no line
  // entry is ever read before it is written. Height may change anywhere.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned pick, w, h, frames, n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      if (script[k].kind == STEP_WRITE) write_reg(script[k].reg_idx, script[k].data);
      else send_pixel(script[k].data[PIX_W-1:0], script[k].typed, script[k].want);
    end

    while (pixels_sent < ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed: small image, whole frames of random pixels
        case ($urandom_range(19))
          0:       w = $urandom_range(1);
          1, 2:    w = $urandom_range(40, 13);
          default: w = $urandom_range(12, 2);
        endcase
        h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
        if (row_pos % 2 == 0) write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        frames = $urandom_range(2, 1);
        repeat (frames) begin
          do send_pixel(PIX_W'($urandom), 1'b0, NO_MEAN);
          while (col_pos != 0 || row_pos != 0);
        end
      end else if (pick < 85) begin
        // largest sizes, only a short run of pixels
        if (row_pos % 2 == 0) begin
          case ($urandom_range(3))
            0:       w = MAX_WIDTH;
            1:       w = 2047;
            2:       w = MAX_WIDTH - 1;
            default: w = $urandom_range(2047, MAX_WIDTH + 1);
          endcase
          write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
        end
        h = $urandom_range(1) ? 65535 : $urandom_range(65535, 1000);
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        n = $urandom_range(60, 10);
        repeat (n) send_pixel(PIX_W'($urandom), 1'b0, NO_MEAN);
      end else begin
        // noise: arbitrary register values mid-frame, broken-off frames
        if (row_pos % 2 == 0 && $urandom_range(1)) write_reg(REG_IMAGE_WIDTH, 16'($urandom));
        if ($urandom_range(1)) write_reg(REG_IMAGE_HEIGHT, 16'($urandom));
        n = $urandom_range(30, 1);
        repeat (n) send_pixel(PIX_W'($urandom), 1'b0, NO_MEAN);
      end
    end

    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failed) $display("SCOREBOARD MISMATCH");
    else $display("SCOREBOARD CLEAN");
    $finish;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted output word with the oldest predicted mean.
  always @(posedge clk) begin : check_means
    mean_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        $error("unexpected word: pixel_out %0d row_end %0b frame_end %0b",
               out_pixel_out, out_row_end, out_frame_end);
        failed = 1'b1;
      end else begin
        want = expected_means.pop_front();
        if (out_pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
          failed = 1'b1;
        end
        if (out_row_end !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, out_row_end);
          failed = 1'b1;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/bds_pkg.sv
design/bds_line_store.sv
design/bds_scan_ctrl.sv
design/box_downscale_2x2_unit.sv
verif/tb.sv
